FILE: sv/cctip_pkg.sv
package cctip_pkg;

  // Configuration register indexes
  localparam int unsigned CFG_INDEX_WIDTH = 3;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    REG_SPHERE_RADIUS      = 3'd0,
    REG_TANGENT_RADIUS     = 3'd1,
    REG_TANGENT_DEPTH      = 3'd2,
    REG_CONE_INVERSE_SLOPE = 3'd3,
    REG_TIP_CENTER         = 3'd4
  } cfg_reg_t;

endpackage

FILE: sv/capped_cone_tip_height_unit.sv
// Channel   Direction  Handshake                      Payload
// s_axis    in         s_axis_tvalid / s_axis_tready  tdata: radial_position
// m_axis    out        m_axis_tvalid / m_axis_tready  tdata: tip_height, tuser: saturated
// cfg       in         cfg_valid / cfg_ready          cfg_index, cfg_data
//
// One item per cycle enters and leaves while the output side takes results.
// The square root takes one pipeline stage per root bit, DATA_WIDTH - 1
// stages, and sets the depth of the pipeline.
// Reset clears the valid bits of every stage and the configuration registers.
// A stalled output holds the whole pipeline; nothing is dropped or repeated.
// Configuration writes are always taken (cfg_ready is tied high).
module capped_cone_tip_height_unit #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                                    clk,
  input  logic                                    rst,
  // radial_position [DATA_WIDTH-1:0]
  input  logic [((DATA_WIDTH+7)/8)*8-1:0]         s_axis_tdata,
  input  logic                                    s_axis_tvalid,
  output logic                                    s_axis_tready,
  // tip_height [DATA_WIDTH-2:0]
  output logic [((DATA_WIDTH+6)/8)*8-1:0]         m_axis_tdata,
  // saturated [0]
  output logic                                    m_axis_tuser,
  output logic                                    m_axis_tvalid,
  input  logic                                    m_axis_tready,
  input  logic                                    cfg_valid,
  output logic                                    cfg_ready,
  input  logic [cctip_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
  input  logic [DATA_WIDTH-1:0]                   cfg_data
);

  localparam int W      = DATA_WIDTH;
  localparam int M      = DATA_WIDTH - 1;
  localparam int RW     = M + 1;
  localparam int PW     = 2 * DATA_WIDTH;
  localparam int OUT_TW = ((DATA_WIDTH+6)/8)*8;

  typedef struct packed {
    logic         in_sph;
    logic         cone_on;
    logic         cone_sat;
    logic [M-1:0] cone_val;
  } side_t;

  // Configuration registers
  logic [M-1:0]        sphere_radius;
  logic [M-1:0]        tangent_radius;
  logic [W-1:0]        tangent_depth;
  logic [M-1:0]        cone_inverse_slope;
  logic [W-1:0]        tip_center;
  logic [W-1:0]        depth_mag;
  logic signed [W:0]   cap;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sphere_radius      <= '0;
      tangent_radius     <= '0;
      tangent_depth      <= '0;
      cone_inverse_slope <= '0;
      tip_center         <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        cctip_pkg::REG_SPHERE_RADIUS:      sphere_radius      <= cfg_data[M-1:0];
        cctip_pkg::REG_TANGENT_RADIUS:     tangent_radius     <= cfg_data[M-1:0];
        cctip_pkg::REG_TANGENT_DEPTH:      tangent_depth      <= cfg_data;
        cctip_pkg::REG_CONE_INVERSE_SLOPE: cone_inverse_slope <= cfg_data[M-1:0];
        cctip_pkg::REG_TIP_CENTER:         tip_center         <= cfg_data;
        default: ;
      endcase
    end
  end

  // Derive the cap height from the static registers in two steps
  always_ff @(posedge clk) begin
    if (rst) begin
      depth_mag <= '0;
      cap       <= '0;
    end else begin
      depth_mag <= tangent_depth[W-1] ? W'(-tangent_depth) : tangent_depth;
      cap       <= $signed({2'b00, sphere_radius} - {1'b0, depth_mag});
    end
  end

  // Global advance: every stage moves when the output register can take data
  logic adv;
  logic out_valid;
  assign adv           = !out_valid || m_axis_tready;
  assign s_axis_tready = adv;

  // Pipeline registers
  logic              v1, v2, v3, v4, vf1, vf2, vf3;
  logic [W:0]        diff1;
  logic [W:0]        d2;
  logic              in_sph3, cone_on3;
  logic [W:0]        dm3;
  logic [M-1:0]      dlo3;
  logic              in_sph4, cone_on4;
  logic [2*M-1:0]    dsq4, rsq4;
  logic [PW-1:0]     p4;
  logic [PW-1:0]     pq;

  logic [RW-1:0]     sq_rem  [0:M];
  logic [M-1:0]      sq_root [0:M];
  logic [2*M-1:0]    sq_rad  [0:M];
  side_t             sq_side [0:M];
  logic              sq_v    [0:M];

  logic [M-1:0]      t_f1;
  side_t             side_f1, side_f2;
  logic signed [W:0] zs_f2;
  logic [W+1:0]      sum_f3;
  logic              csat_f3;
  logic [M-1:0]      tip_height;
  logic              saturated;

  assign pq = p4 >> FRAC_BITS;

  // Valid bits of the front and back stages
  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      sq_v[0]   <= 1'b0;
      vf1       <= 1'b0;
      vf2       <= 1'b0;
      vf3       <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v1        <= s_axis_tvalid;
      v2        <= v1;
      v3        <= v2;
      v4        <= v3;
      sq_v[0]   <= v4;
      vf1       <= sq_v[M];
      vf2       <= vf1;
      vf3       <= vf2;
      out_valid <= vf3;
    end
  end

  // Front stages: distance, range tests, squares and cone product
  always_ff @(posedge clk) begin
    if (adv) begin
      diff1    <= {s_axis_tdata[W-1], s_axis_tdata[W-1:0]} - {tip_center[W-1], tip_center};
      d2       <= diff1[W] ? (W+1)'(-diff1) : diff1;
      in_sph3  <= d2 <= {2'b00, sphere_radius};
      cone_on3 <= d2 >= {2'b00, tangent_radius};
      dm3      <= d2 - {2'b00, tangent_radius};
      dlo3     <= d2[M-1:0];
      in_sph4  <= in_sph3;
      cone_on4 <= cone_on3;
      dsq4     <= dlo3 * dlo3;
      rsq4     <= sphere_radius * sphere_radius;
      p4       <= dm3 * cone_inverse_slope;
      sq_rem[0]            <= '0;
      sq_root[0]           <= '0;
      sq_rad[0]            <= in_sph4 ? rsq4 - dsq4 : '0;
      sq_side[0].in_sph    <= in_sph4;
      sq_side[0].cone_on   <= cone_on4;
      sq_side[0].cone_sat  <= |pq[PW-1:M];
      sq_side[0].cone_val  <= pq[M-1:0];
    end
  end

  // Square root, one root bit per stage
  for (genvar k = 0; k < M; k++) begin : g_sqrt
    logic [M+1:0] remsh;
    logic [M+1:0] trial;
    logic         ge;

    always_comb begin
      remsh = {sq_rem[k][M-1:0], sq_rad[k][2*M-1 -: 2]};
      trial = {sq_root[k], 2'b01};
      ge    = remsh >= trial;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        sq_v[k+1] <= 1'b0;
      end else if (adv) begin
        sq_v[k+1] <= sq_v[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        sq_rem[k+1]  <= ge ? RW'(remsh - trial) : remsh[RW-1:0];
        sq_root[k+1] <= {sq_root[k][M-2:0], ge};
        sq_rad[k+1]  <= {sq_rad[k][2*M-3:0], 2'b00};
        sq_side[k+1] <= sq_side[k];
      end
    end
  end

  // Back stages: sphere part, cap clip, cone sum, saturation
  always_ff @(posedge clk) begin
    if (adv) begin
      t_f1    <= sphere_radius - sq_root[M];
      side_f1 <= sq_side[M];
      side_f2 <= side_f1;
      if (!side_f1.in_sph || ($signed({2'b00, t_f1}) > cap)) begin
        zs_f2 <= cap;
      end else begin
        zs_f2 <= $signed({2'b00, t_f1});
      end
      csat_f3 <= side_f2.cone_on && side_f2.cone_sat;
      sum_f3  <= {zs_f2[W], zs_f2}
                 + ((side_f2.cone_on && !side_f2.cone_sat) ?
                    {3'b000, side_f2.cone_val} : '0);
      priority if (csat_f3 || (!sum_f3[W+1] && (|sum_f3[W:M]))) begin
        tip_height <= '1;
        saturated  <= 1'b1;
      end else if (sum_f3[W+1]) begin
        tip_height <= '0;
        saturated  <= 1'b0;
      end else begin
        tip_height <= sum_f3[M-1:0];
        saturated  <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = OUT_TW'(tip_height);
  assign m_axis_tuser  = saturated;

  // A transfer in reaches the first stage
  assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> v1)
    else $error("accepted item missing from first stage");

  // A stalled output freezes the front stage
  assert property (@(posedge clk) disable iff (rst)
    !adv |=> v1 == $past(v1))
    else $error("front stage moved during stall");

  // Square root remainder stays within bound of the root
  assert property (@(posedge clk) disable iff (rst)
    sq_v[M] |-> {1'b0, sq_rem[M]} <= {1'b0, sq_root[M], 1'b0})
    else $error("square root remainder out of range");

  // A saturated result carries the maximum height
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> &m_axis_tdata[M-1:0])
    else $error("saturated result below maximum");

endmodule
